[rtl/core/nstpm_pkg.sv]
// package for the nearest timestamp pose match core
// field widths, status and function codes, register indexes, unit control types
`timescale 1ns / 1ps

package nstpm_pkg;

  localparam int TimeW   = 52;
  localparam int PosW    = 32;
  localparam int QuatW   = 16;
  localparam int LimitW  = 8;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 52;
  localparam int PoseW   = 3 * PosW + 4 * QuatW;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_HISTORY_LIMIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TIME_GAP  = 1'b1;

  localparam logic [LimitW-1:0] LIMIT_RESET = 8'd100;
  localparam logic [TimeW-1:0]  GAP_RESET   = 52'd100000;

  typedef enum logic [StatusW-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_TOO_FAR  = 2'd2,
    STATUS_MATCHED  = 2'd3
  } status_e;

  typedef struct packed {
    logic sample;
    logic first;
  } cmp_ctrl_t;

endpackage

[rtl/core/nstpm_if.sv]
// item and result channel interfaces of the pose match core
// depends on nstpm_pkg for field widths
`timescale 1ns / 1ps

interface nstpm_item_if
  import nstpm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [TimeW-1:0]        time_stamp;
  logic signed [PosW-1:0]  pos_x;
  logic signed [PosW-1:0]  pos_y;
  logic signed [PosW-1:0]  pos_z;
  logic signed [QuatW-1:0] quat_w;
  logic signed [QuatW-1:0] quat_x;
  logic signed [QuatW-1:0] quat_y;
  logic signed [QuatW-1:0] quat_z;

  modport source (output valid, func, time_stamp, pos_x, pos_y, pos_z,
                  quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, func, time_stamp, pos_x, pos_y, pos_z,
                quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface nstpm_result_if
  import nstpm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic [TimeW-1:0]        time_gap;
  logic [TimeW-1:0]        match_time;
  logic signed [PosW-1:0]  match_x;
  logic signed [PosW-1:0]  match_y;
  logic signed [PosW-1:0]  match_z;
  logic signed [QuatW-1:0] match_qw;
  logic signed [QuatW-1:0] match_qx;
  logic signed [QuatW-1:0] match_qy;
  logic signed [QuatW-1:0] match_qz;

  modport source (output valid, status, time_gap, match_time, match_x, match_y,
                  match_z, match_qw, match_qx, match_qy, match_qz, input ready);
  modport sink (input valid, status, time_gap, match_time, match_x, match_y,
                match_z, match_qw, match_qx, match_qy, match_qz, output ready);
endinterface

[rtl/core/nstpm_gap_unit.sv]
// absolute difference and compare unit, keeps the best candidate of a scan
// depends on nstpm_pkg
`timescale 1ns / 1ps

module nstpm_gap_unit
  import nstpm_pkg::*;
#(
  parameter int SLOT_W = 7
) (
  input  logic              clk_i,
  input  cmp_ctrl_t         ctrl_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [TimeW-1:0]  stime_i,
  input  logic [TimeW-1:0]  qtime_i,
  output logic [TimeW-1:0]  best_gap_o,
  output logic [TimeW-1:0]  best_time_o,
  output logic [SLOT_W-1:0] best_slot_o
);

  logic [TimeW-1:0]  gap;
  logic              take;
  logic [TimeW-1:0]  best_gap_q;
  logic [TimeW-1:0]  best_time_q;
  logic [SLOT_W-1:0] best_slot_q;

  assign gap  = (stime_i >= qtime_i) ? (stime_i - qtime_i) : (qtime_i - stime_i);
  // strict compare keeps the older entry on a tie
  assign take = ctrl_i.sample && (ctrl_i.first || (gap < best_gap_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_gap_q  <= gap;
      best_time_q <= stime_i;
      best_slot_q <= slot_i;
    end
  end

  assign best_gap_o  = best_gap_q;
  assign best_time_o = best_time_q;
  assign best_slot_o = best_slot_q;

endmodule

[rtl/core/nearest_timestamp_pose_match_core.sv]
// channel     dir  handshake       payload
// item_i      in   valid / ready   func, time_stamp, pose (position, quaternion)
// result_o    out  valid / ready   status, time_gap, nearest time and pose
// cfg_*       in   we only         history_limit (index 0), max_time_gap (index 1)
//
// insert, empty query: straight to S_DONE; query: S_SCAN, S_DRAIN, S_POSE, S_DONE
// the query length is set by the single time memory read port, one entry a cycle
// one item at a time: item_i.ready is low from acceptance until the result is loaded
// a finished result waits in the output register; the next item is taken meanwhile
// reset clears pointers, count, config and handshake state; memories need no clearing
//
// history store, scan sequencer and output register of the pose match core
// depends on nstpm_pkg, nstpm_if and nstpm_gap_unit
`timescale 1ns / 1ps

module nearest_timestamp_pose_match_core
  import nstpm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  nstpm_item_if.sink         item_i,
  nstpm_result_if.source     result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = ((CW > LimitW) ? CW : LimitW) + 1;
  localparam logic [PW-1:0] LastSlot = PW'(HISTORY_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_POSE,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [PW-1:0]       oldest_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       issued_q;
  logic [PW-1:0]       rd_ptr_q;
  logic [TimeW-1:0]    qtime_q;
  logic                pend_search_q;
  status_e             pend_status_q;
  cmp_ctrl_t           smp_q;
  logic [PW-1:0]       smp_slot_q;
  logic [LimitW-1:0]   limit_q;
  logic [TimeW-1:0]    max_gap_q;

  logic [TimeW-1:0]    time_mem [HISTORY_DEPTH];
  logic [PoseW-1:0]    pose_mem [HISTORY_DEPTH];
  logic [TimeW-1:0]    time_rd_q;
  logic [PoseW-1:0]    pose_rd_q;

  logic                res_valid_q;
  status_e             res_status_q;
  logic [TimeW-1:0]    res_gap_q;
  logic [TimeW-1:0]    res_time_q;
  logic [PoseW-1:0]    res_pose_q;

  logic [TimeW-1:0]    best_gap;
  logic [TimeW-1:0]    best_time;
  logic [PW-1:0]       best_slot;

  logic                accept;
  logic                do_insert;
  logic [SW-1:0]       slot_sum;
  logic [PW-1:0]       wr_slot;
  logic [LW-1:0]       eff_limit;
  logic [LW-1:0]       count_inc;
  logic                drop_oldest;
  logic                res_free;
  logic                res_load;

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign do_insert    = accept && (item_i.func == FUNC_INSERT);
  assign res_free     = !res_valid_q || result_o.ready;
  assign res_load     = (state_q == S_DONE) && res_free;

  always_comb begin
    slot_sum = SW'(oldest_q) + SW'(count_q);
    if (slot_sum >= SW'(HISTORY_DEPTH)) begin
      slot_sum = slot_sum - SW'(HISTORY_DEPTH);
    end
    wr_slot = slot_sum[PW-1:0];
  end

  always_comb begin
    if (limit_q == '0) begin
      eff_limit = LW'(1);
    end else if (LW'(limit_q) > LW'(HISTORY_DEPTH)) begin
      eff_limit = LW'(HISTORY_DEPTH);
    end else begin
      eff_limit = LW'(limit_q);
    end
    count_inc   = LW'(count_q) + LW'(1);
    drop_oldest = count_inc > eff_limit;
  end

  // history memories
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      time_mem[wr_slot] <= item_i.time_stamp;
      pose_mem[wr_slot] <= {item_i.pos_x, item_i.pos_y, item_i.pos_z, item_i.quat_w,
                            item_i.quat_x, item_i.quat_y, item_i.quat_z};
    end
    time_rd_q <= time_mem[rd_ptr_q];
    if (state_q == S_POSE) begin
      pose_rd_q <= pose_mem[best_slot];
    end
  end

  nstpm_gap_unit #(
    .SLOT_W(PW)
  ) u_gap (
    .clk_i       (clk_i),
    .ctrl_i      (smp_q),
    .slot_i      (smp_slot_q),
    .stime_i     (time_rd_q),
    .qtime_i     (qtime_q),
    .best_gap_o  (best_gap),
    .best_time_o (best_time),
    .best_slot_o (best_slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      max_gap_q <= GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HISTORY_LIMIT: limit_q   <= cfg_wdata_i[LimitW-1:0];
        CFG_MAX_TIME_GAP:  max_gap_q <= cfg_wdata_i[TimeW-1:0];
        default:           ;
      endcase
    end
  end

  // payload registers without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qtime_q <= item_i.time_stamp;
    end
    smp_slot_q <= rd_ptr_q;
    if (res_load) begin
      if (pend_search_q) begin
        res_status_q <= (best_gap > max_gap_q) ? STATUS_TOO_FAR : STATUS_MATCHED;
        res_gap_q    <= best_gap;
        res_time_q   <= best_time;
        res_pose_q   <= pose_rd_q;
      end else begin
        res_status_q <= pend_status_q;
        res_gap_q    <= '0;
        res_time_q   <= '0;
        res_pose_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      oldest_q      <= '0;
      count_q       <= '0;
      issued_q      <= '0;
      rd_ptr_q      <= '0;
      pend_search_q <= 1'b0;
      pend_status_q <= STATUS_INSERTED;
      smp_q         <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      smp_q.sample <= (state_q == S_SCAN);
      smp_q.first  <= (state_q == S_SCAN) && (issued_q == '0);
      res_valid_q  <= res_load || (res_valid_q && !result_o.ready);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            issued_q <= '0;
            rd_ptr_q <= oldest_q;
            if (item_i.func == FUNC_INSERT) begin
              pend_search_q <= 1'b0;
              pend_status_q <= STATUS_INSERTED;
              state_q       <= S_DONE;
              if (drop_oldest) begin
                oldest_q <= (oldest_q == LastSlot) ? '0 : oldest_q + PW'(1);
              end else begin
                count_q <= count_q + CW'(1);
              end
            end else if (count_q == '0) begin
              pend_search_q <= 1'b0;
              pend_status_q <= STATUS_EMPTY;
              state_q       <= S_DONE;
            end else begin
              pend_search_q <= 1'b1;
              state_q       <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_ptr_q <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + PW'(1);
          issued_q <= issued_q + CW'(1);
          if (issued_q == count_q - CW'(1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: state_q <= S_POSE;
        S_POSE:  state_q <= S_DONE;
        S_DONE: begin
          if (res_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.status     = res_status_q;
  assign result_o.time_gap   = res_gap_q;
  assign result_o.match_time = res_time_q;
  assign {result_o.match_x, result_o.match_y, result_o.match_z, result_o.match_qw,
          result_o.match_qx, result_o.match_qy, result_o.match_qz} = res_pose_q;

endmodule

[rtl/core/nstpm_checker.sv]
// port level checks of the pose match core and the bind that attaches them
// depends on nstpm_pkg and nearest_timestamp_pose_match_core
`timescale 1ns / 1ps

module nstpm_port_checker
  import nstpm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [StatusW-1:0] out_status_i,
  input logic [TimeW-1:0]   out_gap_i,
  input logic [TimeW-1:0]   out_time_i
);

  // a pending result is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transaction");

  // one transaction at a time in the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while busy");

  // insert and empty answers carry no gap or time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_INSERTED || out_status_i == STATUS_EMPTY)
    |-> out_gap_i == '0 && out_time_i == '0)
    else $error("non-search result with payload");

  // too far means a gap above some threshold, so never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STATUS_TOO_FAR |-> out_gap_i != '0)
    else $error("too far with zero gap");

endmodule

bind nearest_timestamp_pose_match_core nstpm_port_checker u_nstpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_gap_i    (result_o.time_gap),
  .out_time_i   (result_o.match_time)
);

[tb/nstpm_checker.sv]
// passive checker for the nearest timestamp pose match core
// watches the item, result and register write ports, predicts every answer and compares
// depends on nstpm_pkg and the nstpm_if channel interfaces
`timescale 1ns / 1ps

module nstpm_checker
  import nstpm_pkg::*;
#(
  parameter int HistDepth = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  nstpm_item_if              item_mon,
  nstpm_result_if            result_mon,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int                 pending_o,
  output int                 errors_o
);

  localparam int AwaitDepth = 8;

  typedef struct packed {
    logic [TimeW-1:0]        stamp;
    logic signed [PosW-1:0]  x;
    logic signed [PosW-1:0]  y;
    logic signed [PosW-1:0]  z;
    logic signed [QuatW-1:0] qw;
    logic signed [QuatW-1:0] qx;
    logic signed [QuatW-1:0] qy;
    logic signed [QuatW-1:0] qz;
  } pose_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TimeW-1:0]   gap;
    pose_t              pose;
  } answer_t;

  pose_t             pose_history [HistDepth];
  int unsigned       oldest_slot;
  int unsigned       kept_count;
  logic [LimitW-1:0] keep_limit;
  logic [TimeW-1:0]  gap_limit;
  answer_t           awaited_answers [AwaitDepth];
  int unsigned       await_head;
  int unsigned       await_count;
  answer_t           head_answer;
  pose_t             seen_item;

  function automatic answer_t predict_answer(input logic fn, input pose_t p);
    answer_t          ans;
    int unsigned      slot;
    int unsigned      cap;
    int unsigned      best;
    logic [TimeW-1:0] cand_gap;
    ans = '0;
    if (fn == FUNC_INSERT) begin
      slot = (oldest_slot + kept_count) % HistDepth;
      pose_history[slot] = p;
      kept_count++;
      cap = (keep_limit == '0) ? 1 : int'(keep_limit);
      if (cap > HistDepth) cap = HistDepth;
      // only one oldest pose leaves per insert, even after the limit was lowered
      if (kept_count > cap || kept_count > HistDepth) begin
        oldest_slot = (oldest_slot + 1) % HistDepth;
        kept_count--;
      end
      ans.status = STATUS_INSERTED;
    end else if (kept_count == 0) begin
      ans.status = STATUS_EMPTY;
    end else begin
      best = oldest_slot;
      for (int unsigned i = 0; i < kept_count; i++) begin
        slot = (oldest_slot + i) % HistDepth;
        cand_gap = (pose_history[slot].stamp >= p.stamp) ? pose_history[slot].stamp - p.stamp
                                                          : p.stamp - pose_history[slot].stamp;
        // strict compare keeps the older pose on a tie
        if (i == 0 || cand_gap < ans.gap) begin
          ans.gap = cand_gap;
          best = slot;
        end
      end
      ans.pose = pose_history[best];
      ans.status = (ans.gap > gap_limit) ? STATUS_TOO_FAR : STATUS_MATCHED;
    end
    return ans;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors_o++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_slot = 0;
      kept_count = 0;
      keep_limit = LIMIT_RESET;
      gap_limit = GAP_RESET;
      errors_o = 0;
      await_head = 0;
      await_count = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HISTORY_LIMIT) keep_limit = cfg_wdata_i[LimitW-1:0];
        else if (cfg_idx_i == CFG_MAX_TIME_GAP) gap_limit = cfg_wdata_i[TimeW-1:0];
      end
      if (result_mon.valid && result_mon.ready) begin
        if (await_count == 0) begin
          errors_o++;
          $error("result transaction with no answer pending");
        end else begin
          head_answer = awaited_answers[await_head % AwaitDepth];
          await_head++;
          await_count--;
          check_field("status", head_answer.status, result_mon.status);
          check_field("time_gap", head_answer.gap, result_mon.time_gap);
          check_field("match_time", head_answer.pose.stamp, result_mon.match_time);
          check_field("match_x", head_answer.pose.x, result_mon.match_x);
          check_field("match_y", head_answer.pose.y, result_mon.match_y);
          check_field("match_z", head_answer.pose.z, result_mon.match_z);
          check_field("match_qw", head_answer.pose.qw, result_mon.match_qw);
          check_field("match_qx", head_answer.pose.qx, result_mon.match_qx);
          check_field("match_qy", head_answer.pose.qy, result_mon.match_qy);
          check_field("match_qz", head_answer.pose.qz, result_mon.match_qz);
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        seen_item.stamp = item_mon.time_stamp;
        seen_item.x = item_mon.pos_x;
        seen_item.y = item_mon.pos_y;
        seen_item.z = item_mon.pos_z;
        seen_item.qw = item_mon.quat_w;
        seen_item.qx = item_mon.quat_x;
        seen_item.qy = item_mon.quat_y;
        seen_item.qz = item_mon.quat_z;
        if (await_count == AwaitDepth) begin
          errors_o++;
          $error("more answers pending than the core can hold");
        end else begin
          awaited_answers[(await_head + await_count) % AwaitDepth] =
            predict_answer(item_mon.func, seen_item);
          await_count++;
        end
      end
    end
    pending_o = await_count;
  end

endmodule

[tb/testbench.sv]
// top of the pose match core testbench: clock, reset, register writes and channel stimulus
// depends on nstpm_pkg, nstpm_if, the core and nstpm_checker
`timescale 1ns / 1ps

module testbench;
  import nstpm_pkg::*;

  localparam int HistDepth    = 128;
  localparam int PhaseItems   = 152;
  localparam int HoldCycles   = 400;
  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 150;
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef struct packed {
    logic [TimeW-1:0]        stamp;
    logic signed [PosW-1:0]  x;
    logic signed [PosW-1:0]  y;
    logic signed [PosW-1:0]  z;
    logic signed [QuatW-1:0] qw;
    logic signed [QuatW-1:0] qx;
    logic signed [QuatW-1:0] qy;
    logic signed [QuatW-1:0] qz;
  } pose_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  int                 pending;
  int                 errors;

  bit                 tx_burst;
  bit                 rx_burst;
  bit                 hold_req;
  logic [TimeW-1:0]   clock_us;
  logic [TimeW-1:0]   recent_stamps [8];
  int unsigned        recent_next;
  int                 n_insert;
  int                 n_query;
  int                 n_settings;

  nstpm_item_if   item_ch ();
  nstpm_result_if result_ch ();

  nearest_timestamp_pose_match_core #(
    .HISTORY_DEPTH(HistDepth)
  ) dut (
    .clk_i,
    .rst_ni,
    .item_i     (item_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  nstpm_checker #(
    .HistDepth(HistDepth)
  ) match_checker (
    .clk_i,
    .rst_ni,
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic pose_t random_pose(input logic [TimeW-1:0] ts);
    pose_t p;
    p.stamp = ts;
    p.x = $urandom();
    p.y = $urandom();
    p.z = $urandom();
    p.qw = 16'($urandom());
    p.qx = 16'($urandom());
    p.qy = 16'($urandom());
    p.qz = 16'($urandom());
    return p;
  endfunction

  function automatic pose_t extreme_pose(input logic [TimeW-1:0] ts, input logic flip);
    pose_t p;
    p.stamp = ts;
    p.x = 32'h7fff_ffff;
    p.y = 32'h8000_0000;
    p.z = '0;
    p.qw = 16'h7fff;
    p.qx = 16'h8000;
    p.qy = 16'hffff;
    p.qz = '0;
    if (flip) {p.x, p.y, p.z, p.qw, p.qx, p.qy, p.qz} = ~{p.x, p.y, p.z, p.qw, p.qx, p.qy, p.qz};
    return p;
  endfunction

  // called at a rising edge, returns at the edge that accepts the transaction
  task automatic drive_item(input logic fn, input pose_t p);
    int unsigned wait_cycles;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    wait_cycles = tx_burst ? 0 : $urandom_range(0, 11);
    if (wait_cycles != 0) begin
      item_ch.valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.func <= fn;
    item_ch.time_stamp <= p.stamp;
    item_ch.pos_x <= p.x;
    item_ch.pos_y <= p.y;
    item_ch.pos_z <= p.z;
    item_ch.quat_w <= p.qw;
    item_ch.quat_x <= p.qx;
    item_ch.quat_y <= p.qy;
    item_ch.quat_z <= p.qz;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    if (fn == FUNC_INSERT) n_insert++;
    else n_query++;
  endtask

  task automatic insert_pose(input logic [TimeW-1:0] ts);
    drive_item(FUNC_INSERT, random_pose(ts));
    recent_stamps[recent_next % 8] = ts;
    recent_next++;
  endtask

  task automatic query_at(input logic [TimeW-1:0] ts);
    drive_item(FUNC_QUERY, random_pose(ts));
  endtask

  function automatic logic [TimeW-1:0] next_insert_stamp();
    case ($urandom_range(0, 19))
      0: clock_us = TimeW'({$urandom(), $urandom()});
      1: ;  // same time as the previous pose
      2: clock_us = clock_us - TimeW'($urandom_range(1, 30000));
      default: clock_us = clock_us + TimeW'($urandom_range(1, 40000));
    endcase
    return clock_us;
  endfunction

  function automatic logic [TimeW-1:0] query_stamp();
    logic [TimeW-1:0] base;
    logic [TimeW:0]   pair_sum;
    base = recent_stamps[$urandom_range(0, 7)];
    pair_sum = {1'b0, recent_stamps[(recent_next - 1) % 8]}
             + {1'b0, recent_stamps[(recent_next - 2) % 8]};
    case ($urandom_range(0, 9))
      0: return base;
      1, 2, 3, 4: return base + TimeW'($urandom_range(0, 80000)) - TimeW'($urandom_range(0, 80000));
      5: return pair_sum[TimeW:1];  // halfway between the two newest poses
      6: return clock_us + TimeW'({$urandom_range(1, 4095), $urandom()});
      7: return TimeW'({$urandom(), $urandom()});
      8: return base - TimeW'($urandom_range(0, 300000));
      default: return $urandom_range(0, 1) ? TimeMax : '0;
    endcase
  endfunction

  // drop valid and wait until every answer is back
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [LimitW-1:0] limit, input logic [TimeW-1:0] gap);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_HISTORY_LIMIT;
    cfg_wdata <= CfgW'(limit);
    @(posedge clk_i);
    cfg_idx <= CFG_MAX_TIME_GAP;
    cfg_wdata <= gap;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : result_sink
    int unsigned stall;
    result_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (hold_req) begin
        stall = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_ch.valid) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [LimitW-1:0] limit;
    logic [TimeW-1:0]  gap;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_HISTORY_LIMIT;
    cfg_wdata <= '0;
    item_ch.valid <= 1'b0;
    item_ch.func <= FUNC_INSERT;
    item_ch.time_stamp <= '0;
    item_ch.pos_x <= '0;
    item_ch.pos_y <= '0;
    item_ch.pos_z <= '0;
    item_ch.quat_w <= '0;
    item_ch.quat_x <= '0;
    item_ch.quat_y <= '0;
    item_ch.quat_z <= '0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    hold_req = 1'b0;
    clock_us = TimeW'($urandom_range(0, 1000000));
    recent_next = 0;
    n_insert = 0;
    n_query = 0;
    n_settings = 0;
    foreach (recent_stamps[i]) recent_stamps[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty history under the reset settings
    query_at(52'd12345);
    query_at('0);
    // limit of zero keeps a single pose, zero gap matches only exact times
    set_regs(8'd0, '0);
    drive_item(FUNC_INSERT, extreme_pose(52'd5, 1'b0));
    drive_item(FUNC_INSERT, extreme_pose(52'd7, 1'b1));
    query_at(52'd5);
    query_at(52'd7);
    set_regs(8'd2, 52'd100000);
    insert_pose(52'd1000);
    insert_pose('0);
    query_at(52'd500);
    query_at(52'd1000);
    set_regs(8'd4, 52'd100000);
    insert_pose(TimeMax);
    query_at(TimeMax);
    query_at(52'd101000);
    query_at(52'd101001);
    query_at(52'd1 << 51);
    insert_pose(52'd1000);
    query_at(52'd1000);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin limit = 8'd1; gap = 52'd100000; end
        1: begin limit = 8'd2; gap = '0; end
        2: begin limit = 8'd7; gap = TimeMax; end
        3: begin limit = 8'd64; gap = 52'd1; end
        4: begin limit = 8'd100; gap = 52'd50000; end
        5: begin limit = 8'd127; gap = TimeW'({$urandom(), $urandom()}); end
        6: begin limit = 8'd128; gap = 52'd20000; end
        7: begin limit = 8'd3; gap = 52'd100000; end
        8: begin limit = 8'd255; gap = 52'd200000; end
        9: begin limit = 8'd129; gap = '0; end
        10: begin limit = 8'd0; gap = TimeMax; end
        default: begin
          limit = 8'($urandom_range(0, 255));
          gap = TimeW'($urandom_range(0, 300000));
        end
      endcase
      set_regs(limit, gap);
      if (ph == 5) hold_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(0, 9) < 6) insert_pose(next_insert_stamp());
        else query_at(query_stamp());
      end
    end

    settle();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d pose inserts and %0d nearest-time queries over %0d register settings",
             n_insert, n_query, n_settings);
    $display("history limits from 0 to 255, gap limits from 0 to full scale, one long hold-off");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
